@@ rtl/core/ip6opt_pkg.sv @@
// Shared types and codes for the IPv6 options header checker.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package ip6opt_pkg;

    // Walk phase of the outer option parser
    typedef enum logic [2:0] {
        PH_NH   = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_OLEN = 3'd3,
        PH_VAL  = 3'd4,
        PH_SUB  = 3'd5,
        PH_WAIT = 3'd6
    } t_phase;

    // Sub-option phase inside a Home Address option
    localparam logic [1:0] SUB_TYPE = 2'd0;
    localparam logic [1:0] SUB_LEN  = 2'd1;
    localparam logic [1:0] SUB_VAL  = 2'd2;

    // Byte roles
    localparam logic [3:0] ROLE_NEXT_HDR = 4'd0;
    localparam logic [3:0] ROLE_HDR_LEN  = 4'd1;
    localparam logic [3:0] ROLE_OPT_TYPE = 4'd2;
    localparam logic [3:0] ROLE_OPT_LEN  = 4'd3;
    localparam logic [3:0] ROLE_OPT_VAL  = 4'd4;
    localparam logic [3:0] ROLE_SUB_TYPE = 4'd5;
    localparam logic [3:0] ROLE_SUB_LEN  = 4'd6;
    localparam logic [3:0] ROLE_SUB_VAL  = 4'd7;
    localparam logic [3:0] ROLE_IGNORED  = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TRUNC   = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    // Jumbo check codes
    localparam logic [2:0] JC_NONE     = 3'd0;
    localparam logic [2:0] JC_VALID    = 3'd1;
    localparam logic [2:0] JC_REPEATED = 3'd2;
    localparam logic [2:0] JC_NOT_HBH  = 3'd3;
    localparam logic [2:0] JC_PAYLOAD  = 3'd4;
    localparam logic [2:0] JC_SMALL    = 3'd5;

    // Option type codes and length rules
    localparam logic [7:0]  OPT_PAD1      = 8'd0;
    localparam logic [7:0]  OPT_RTALERT   = 8'd5;
    localparam logic [7:0]  OPT_JUMBO     = 8'd194;
    localparam logic [7:0]  OPT_HOMEADDR  = 8'd201;
    localparam logic [7:0]  RTALERT_LEN   = 8'd2;
    localparam logic [7:0]  JUMBO_LEN     = 8'd4;
    localparam logic [7:0]  HOMEADDR_LEN  = 8'd16;
    localparam logic [31:0] JUMBO_MIN     = 32'd65536;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       header_start;
        logic       capture_end;
        logic       header_kind;
        logic       ipv6_payload_is_zero;
    } t_item;

    typedef struct packed {
        logic [3:0]  byte_role;
        logic [7:0]  current_option;
        logic [1:0]  status;
        logic        header_done;
        logic [2:0]  jumbo_check;
        logic        jumbo_valid;
        logic [31:0] jumbo_length;
    } t_result;

    typedef struct packed {
        logic [11:0] header_offset;
        logic [11:0] header_total;
        t_phase      phase;
        logic [7:0]  opt_type;
        logic [8:0]  opt_left;
        logic [8:0]  sub_left;
        logic [1:0]  sub_phase;
        logic [8:0]  sub_bytes_left;
        logic [31:0] jumbo_gather;
        logic        jumbo_seen;
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/ip6opt_if.sv @@
// Valid/ready channel interfaces for the IPv6 options header checker.
// Input channel carries one header byte with framing; output carries the result.
`default_nettype none

interface ip6opt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       header_start;
    logic       capture_end;
    logic       header_kind;
    logic       ipv6_payload_is_zero;

    modport source (
        output valid, data_byte, header_start, capture_end, header_kind,
               ipv6_payload_is_zero,
        input  ready
    );
    modport sink (
        input  valid, data_byte, header_start, capture_end, header_kind,
               ipv6_payload_is_zero,
        output ready
    );
endinterface

interface ip6opt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  byte_role;
    logic [7:0]  current_option;
    logic [1:0]  status;
    logic        header_done;
    logic [2:0]  jumbo_check;
    logic        jumbo_valid;
    logic [31:0] jumbo_length;

    modport source (
        output valid, byte_role, current_option, status, header_done, jumbo_check,
               jumbo_valid, jumbo_length,
        input  ready
    );
    modport sink (
        input  valid, byte_role, current_option, status, header_done, jumbo_check,
               jumbo_valid, jumbo_length,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/ip6opt_step.sv @@
// Per-byte parse step: next parser state and result for one header byte.
// Depends on ip6opt_pkg.
`default_nettype none

module ip6opt_step (
    input  wire ip6opt_pkg::t_state  i_state,
    input  wire ip6opt_pkg::t_item   i_item,
    output ip6opt_pkg::t_state       o_state,
    output ip6opt_pkg::t_result      o_result
);
    import ip6opt_pkg::*;

    logic [7:0]  b;
    logic        start;
    logic        walking;
    logic [11:0] rem;
    logic [12:0] orem;
    logic [12:0] olen;
    logic        fin;
    logic [1:0]  walk_err;
    logic [1:0]  err;
    logic [8:0]  opt_left_dec;
    logic [8:0]  sub_left_dec;
    logic [8:0]  sub_bytes_dec;
    logic [31:0] gather_n;
    logic        jumbo_fire;
    logic [2:0]  jumbo_code;

    assign b       = i_item.data_byte;
    assign start   = i_item.header_start || (i_state.phase == PH_NH);
    assign walking = (i_state.phase == PH_TYPE) || (i_state.phase == PH_OLEN) ||
                     (i_state.phase == PH_VAL)  || (i_state.phase == PH_SUB);

    // Shared walk flags
    always_comb begin
        rem  = (i_state.header_total > i_state.header_offset) ?
               i_state.header_total - i_state.header_offset : 12'd0;
        orem = {1'b0, rem} + 13'd1;
        olen = {5'd0, b} + 13'd2;
        fin  = ({1'b0, i_state.header_offset} + 13'd1) >= {1'b0, i_state.header_total};

        opt_left_dec  = (i_state.opt_left != 9'd0) ? i_state.opt_left - 9'd1
                                                   : i_state.opt_left;
        sub_left_dec  = (i_state.sub_left != 9'd0) ? i_state.sub_left - 9'd1
                                                   : i_state.sub_left;
        sub_bytes_dec = (i_state.sub_bytes_left != 9'd0) ? i_state.sub_bytes_left - 9'd1
                                                         : i_state.sub_bytes_left;
        gather_n      = {i_state.jumbo_gather[23:0], b};

        walk_err = ST_OK;
        case (i_state.phase)
            PH_TYPE: begin
                if (b != OPT_PAD1 && rem < 12'd2) walk_err = ST_TRUNC;
            end
            PH_OLEN: begin
                if (olen > orem) begin
                    walk_err = ST_TRUNC;
                end else if (i_state.opt_type == OPT_RTALERT) begin
                    if (orem < 13'd4)         walk_err = ST_TRUNC;
                    else if (b != RTALERT_LEN) walk_err = ST_BAD_LEN;
                end else if (i_state.opt_type == OPT_JUMBO) begin
                    if (orem < 13'd6)       walk_err = ST_TRUNC;
                    else if (b != JUMBO_LEN) walk_err = ST_BAD_LEN;
                end else if (i_state.opt_type == OPT_HOMEADDR) begin
                    if (orem < 13'd18)         walk_err = ST_TRUNC;
                    else if (b < HOMEADDR_LEN) walk_err = ST_BAD_LEN;
                end
            end
            PH_SUB: begin
                if (i_state.sub_phase == SUB_TYPE) begin
                    if (b != OPT_PAD1 && i_state.sub_left < 9'd2) walk_err = ST_TRUNC;
                end else if (i_state.sub_phase == SUB_LEN) begin
                    if (({2'd0, b} + 10'd2) > ({1'b0, i_state.sub_left} + 10'd1))
                        walk_err = ST_TRUNC;
                end
            end
            default: walk_err = ST_OK;
        endcase

        // Early capture end outranks a length fault on the same byte
        err = (i_item.capture_end && !fin) ? ST_TRUNC : walk_err;

        jumbo_fire = (i_state.phase == PH_VAL) && (opt_left_dec == 9'd0) &&
                     (i_state.opt_type == OPT_JUMBO);
        if (i_state.jumbo_seen)               jumbo_code = JC_REPEATED;
        else if (i_item.header_kind)          jumbo_code = JC_NOT_HBH;
        else if (!i_item.ipv6_payload_is_zero) jumbo_code = JC_PAYLOAD;
        else if (gather_n < JUMBO_MIN)        jumbo_code = JC_SMALL;
        else                                  jumbo_code = JC_VALID;
    end

    // Next state
    always_comb begin
        o_state = i_state;
        if (start) begin
            o_state.jumbo_seen    = 1'b0;
            o_state.header_offset = 12'd1;
            o_state.phase         = i_item.capture_end ? PH_WAIT : PH_LEN;
        end else if (i_state.phase == PH_LEN) begin
            o_state.header_total  = {({1'b0, b} + 9'd1), 3'b000};
            o_state.header_offset = 12'd2;
            o_state.phase         = i_item.capture_end ? PH_WAIT : PH_TYPE;
        end else if (walking) begin
            case (i_state.phase)
                PH_TYPE: begin
                    o_state.opt_type = b;
                    if (b != OPT_PAD1 && walk_err == ST_OK) o_state.phase = PH_OLEN;
                end
                PH_OLEN: begin
                    if (walk_err == ST_OK) begin
                        o_state.jumbo_gather = 32'd0;
                        if (b == 8'd0) begin
                            o_state.phase = PH_TYPE;
                        end else if (i_state.opt_type == OPT_HOMEADDR) begin
                            o_state.opt_left  = {1'b0, HOMEADDR_LEN};
                            o_state.sub_left  = {1'b0, b} - {1'b0, HOMEADDR_LEN};
                            o_state.sub_phase = SUB_TYPE;
                            o_state.phase     = PH_VAL;
                        end else begin
                            o_state.opt_left = {1'b0, b};
                            o_state.phase    = PH_VAL;
                        end
                    end
                end
                PH_VAL: begin
                    o_state.jumbo_gather = gather_n;
                    o_state.opt_left     = opt_left_dec;
                    if (opt_left_dec == 9'd0) begin
                        o_state.phase = PH_TYPE;
                        if (i_state.opt_type == OPT_JUMBO) begin
                            o_state.jumbo_seen = 1'b1;
                        end else if (i_state.opt_type == OPT_HOMEADDR &&
                                     i_state.sub_left != 9'd0) begin
                            o_state.phase     = PH_SUB;
                            o_state.sub_phase = SUB_TYPE;
                        end
                    end
                end
                PH_SUB: begin
                    if (i_state.sub_phase == SUB_TYPE) begin
                        if (b != OPT_PAD1 && walk_err == ST_OK) o_state.sub_phase = SUB_LEN;
                    end else if (i_state.sub_phase == SUB_LEN) begin
                        if (walk_err == ST_OK) begin
                            o_state.sub_bytes_left = {1'b0, b};
                            o_state.sub_phase      = (b == 8'd0) ? SUB_TYPE : SUB_VAL;
                        end
                    end else begin
                        o_state.sub_bytes_left = sub_bytes_dec;
                        if (sub_bytes_dec == 9'd0) o_state.sub_phase = SUB_TYPE;
                    end
                    o_state.sub_left = sub_left_dec;
                    if (walk_err == ST_OK && sub_left_dec == 9'd0) begin
                        o_state.phase     = PH_TYPE;
                        o_state.sub_phase = SUB_TYPE;
                    end
                end
                default: o_state.phase = PH_WAIT;
            endcase
            o_state.header_offset = i_state.header_offset + 12'd1;
            if (err != ST_OK || fin) o_state.phase = PH_WAIT;
        end else begin
            o_state.phase = PH_WAIT;
        end
    end

    // Result
    always_comb begin
        o_result              = '0;
        o_result.byte_role    = ROLE_IGNORED;
        if (start) begin
            o_result.byte_role = ROLE_NEXT_HDR;
            if (i_item.capture_end) begin
                o_result.status      = ST_TRUNC;
                o_result.header_done = 1'b1;
            end
        end else if (i_state.phase == PH_LEN) begin
            o_result.byte_role = ROLE_HDR_LEN;
            if (i_item.capture_end) begin
                o_result.status      = ST_TRUNC;
                o_result.header_done = 1'b1;
            end
        end else if (walking) begin
            o_result.current_option = i_state.opt_type;
            case (i_state.phase)
                PH_TYPE: begin
                    o_result.byte_role      = ROLE_OPT_TYPE;
                    o_result.current_option = b;
                end
                PH_OLEN: o_result.byte_role = ROLE_OPT_LEN;
                PH_VAL:  o_result.byte_role = ROLE_OPT_VAL;
                PH_SUB: begin
                    if (i_state.sub_phase == SUB_TYPE)     o_result.byte_role = ROLE_SUB_TYPE;
                    else if (i_state.sub_phase == SUB_LEN) o_result.byte_role = ROLE_SUB_LEN;
                    else                                   o_result.byte_role = ROLE_SUB_VAL;
                end
                default: o_result.byte_role = ROLE_IGNORED;
            endcase
            if (err != ST_OK) begin
                o_result.status      = err;
                o_result.header_done = 1'b1;
            end else begin
                o_result.header_done = fin;
                if (jumbo_fire) begin
                    o_result.jumbo_check  = jumbo_code;
                    o_result.jumbo_valid  = (jumbo_code == JC_VALID);
                    o_result.jumbo_length = gather_n;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ipv6_option_tlv_checker.sv @@
// A result is registered and appears in the cycle after its byte is taken in.
// Throughput: one byte per cycle unless stalled; the parse step is one pass of
//   compare and counter logic between the parser state and result registers.
// The result register accepts a new byte while its result is being taken, so
//   a stall on the output costs only the cycles it lasts.
// Reset (synchronous, active low) empties the result register and returns the
//   parser to expecting a next-header byte. Depends on ip6opt_pkg, ip6opt_if.
`default_nettype none

module ipv6_option_tlv_checker (
    input  wire             i_clk,
    input  wire             i_rst_n,
    ip6opt_in_if.sink       i_in,
    ip6opt_out_if.source    o_out
);
    import ip6opt_pkg::*;

    t_item   w_item;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_result;
    logic    r_out_valid;
    logic    w_accept;

    // Gather the input payload into one word for the step logic
    assign w_item.data_byte            = i_in.data_byte;
    assign w_item.header_start         = i_in.header_start;
    assign w_item.capture_end          = i_in.capture_end;
    assign w_item.header_kind          = i_in.header_kind;
    assign w_item.ipv6_payload_is_zero = i_in.ipv6_payload_is_zero;

    // Take a byte whenever the result register is empty or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    ip6opt_step u_step (
        .i_state  (r_state),
        .i_item   (w_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Parser state: advance only on a transfer in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_state.phase <= PH_NH;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // Result register: load on a transfer in, drop once the sink has it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; hold it while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.byte_role      = r_out.byte_role;
    assign o_out.current_option = r_out.current_option;
    assign o_out.status         = r_out.status;
    assign o_out.header_done    = r_out.header_done;
    assign o_out.jumbo_check    = r_out.jumbo_check;
    assign o_out.jumbo_valid    = r_out.jumbo_valid;
    assign o_out.jumbo_length   = r_out.jumbo_length;

    // Every transfer in leaves a result waiting
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("transfer in did not produce a result");

    // A stalled result is neither lost nor replaced
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

    // Any error ends the header and parks the parser
    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_result.status != ST_OK |=>
            r_out.header_done && r_state.phase == PH_WAIT)
        else $error("error did not stop the parse");

    // A valid jumbo flag only ever comes with the valid check code
    a_jumbo_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.jumbo_valid |->
            r_out.jumbo_check == JC_VALID && r_out.status == ST_OK)
        else $error("jumbo flag and check code disagree");

endmodule

`default_nettype wire
